// ===== src/gsrs_pkg.sv =====
`default_nettype none

package gsrs_pkg;

   // data bytes served after the three header bytes
   localparam int unsigned REPLY_BYTES = 6;

   localparam int unsigned POLL_BYTES = 6;
   localparam int unsigned POLL_W     = 8 * POLL_BYTES;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 4;

   localparam logic [POLL_W-1:0] POLL_RESET = 48'hF7F7_F7F7_BFBF;

   localparam logic [3:0] POS_MAX = 4'hF;

   localparam logic [7:0] TX_IDLE     = 8'hFF;
   localparam logic [7:0] TX_ID_TAIL  = 8'h5A;
   localparam logic [7:0] MODE_DIG    = 8'h41;
   localparam logic [7:0] MODE_CONFIG = 8'hF3;
   localparam logic [7:0] MODE_ANALOG = 8'h71;

   localparam logic [7:0] CMD_41 = 8'h41;
   localparam logic [7:0] CMD_43 = 8'h43;
   localparam logic [7:0] CMD_44 = 8'h44;
   localparam logic [7:0] CMD_45 = 8'h45;
   localparam logic [7:0] CMD_46 = 8'h46;
   localparam logic [7:0] CMD_47 = 8'h47;
   localparam logic [7:0] CMD_4C = 8'h4C;
   localparam logic [7:0] CMD_4D = 8'h4D;

   // reply table codes
   localparam logic [3:0] TBL_POLL   = 4'd0;
   localparam logic [3:0] TBL_41     = 4'd1;
   localparam logic [3:0] TBL_43A    = 4'd2;
   localparam logic [3:0] TBL_43B    = 4'd3;
   localparam logic [3:0] TBL_44     = 4'd4;
   localparam logic [3:0] TBL_45     = 4'd5;
   localparam logic [3:0] TBL_46A    = 4'd6;
   localparam logic [3:0] TBL_46B    = 4'd7;
   localparam logic [3:0] TBL_47     = 4'd8;
   localparam logic [3:0] TBL_4CA    = 4'd9;
   localparam logic [3:0] TBL_4CB    = 4'd10;
   localparam logic [3:0] TBL_4D     = 4'd11;

   localparam logic [CSR_ADDR_W-1:0] ADDR_POLL_REPLY = 4'h0;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
      logic       select_low;
   } req_item_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_done;
      logic [3:0] bytes_received;
   } rsp_item_type;

   // fixed reply tables, eight columns each
   function automatic logic [7:0] table_byte(input logic [3:0] sel, input logic [2:0] idx);
      logic [63:0] row;
      case (sel)
         TBL_43A, TBL_43B: row = 64'h0000_0000_0000_FFFF;
         TBL_45:           row = 64'h0000_0000_0200_0202;
         TBL_46A:          row = 64'h0000_0A00_0200_0000;
         TBL_46B:          row = 64'h0000_1400_0000_0000;
         TBL_47:           row = 64'h0000_0000_0002_0000;
         TBL_4CA:          row = 64'h0000_0000_0400_0000;
         TBL_4CB:          row = 64'h0000_0000_0600_0000;
         TBL_4D:           row = 64'h0000_FFFF_FFFF_FFFF;
         default:          row = 64'h0;
      endcase
      return row[{idx, 3'b000} +: 8];
   endfunction

endpackage

`default_nettype wire

// ===== src/gsrs_if.sv =====
`default_nettype none

interface gsrs_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;
   logic       select_low;

   modport source (output valid, op, rx_byte, select_low, input ready);
   modport sink   (input valid, op, rx_byte, select_low, output ready);
endinterface

interface gsrs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       frame_done;
   logic [3:0] bytes_received;

   modport source (output valid, tx_byte, frame_done, bytes_received, input ready);
   modport sink   (input valid, tx_byte, frame_done, bytes_received, output ready);
endinterface

`default_nettype wire

// ===== src/gamepad_spi_reply_sequencer.sv =====
// Gamepad serial poll reply sequencer, slave side.
// req channel: one beat per event, op = 1 for a frame restart (select
//   asserted), op = 0 for a byte exchanged with the host, carrying the
//   received byte and the sampled select level.
// rsp channel: one beat per req beat, in order: the next byte to load into
//   the shifter, the latched frame-done flag and the saturating byte count.
// A frame answers 0xFF, the mode byte, 0x5A, then six data bytes from the
//   table picked by the second received byte, then 0x00.
// csr port: APB-style, register 0 at byte address 0 holds the six poll
//   reply bytes (first byte in bits 7:0); pready is tied high.
// Path: from req accept to rsp valid a beat passes the input register,
//   then the decode and result register. Throughput: one beat per cycle
//   while rsp.ready holds; the frame state is read and updated in the single decode stage.
// Reset (synchronous): no beats in flight, frame state as after a restart,
//   mode 0x41, poll table selected, poll bytes at their default.
// When the rsp side stalls the result register holds, the input register
//   fills behind it, and req.ready then drops until rsp.ready returns.
`default_nettype none

module gamepad_spi_reply_sequencer
   import gsrs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   gsrs_req_if.sink                   req,
   gsrs_rsp_if.source                 rsp,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic [POLL_W-1:0] poll_reply;
   req_item_type      req_item;
   req_item_type      stage_item;
   logic              stage_valid;
   logic              stage_ready;
   rsp_item_type      rsp_item;

   gsrs_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .pready     (csr_pready),
      .poll_reply (poll_reply)
   );

   assign req_item.op         = req.op;
   assign req_item.rx_byte    = req.rx_byte;
   assign req_item.select_low = req.select_low;

   // capture the request beat
   gsrs_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_item   (req_item),
      .out_valid (stage_valid),
      .out_ready (stage_ready),
      .out_item  (stage_item)
   );

   // frame state, command decode and result register
   gsrs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .poll_reply (poll_reply),
      .in_valid   (stage_valid),
      .in_ready   (stage_ready),
      .in_item    (stage_item),
      .out_valid  (rsp.valid),
      .out_ready  (rsp.ready),
      .out_item   (rsp_item)
   );

   assign rsp.tx_byte        = rsp_item.tx_byte;
   assign rsp.frame_done     = rsp_item.frame_done;
   assign rsp.bytes_received = rsp_item.bytes_received;

endmodule

`default_nettype wire

// ===== src/gsrs_csr.sv =====
`default_nettype none

module gsrs_csr
   import gsrs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output logic      [POLL_W-1:0]     poll_reply
);

   logic [POLL_W-1:0] poll_ff;
   logic [POLL_W-1:0] poll_in;
   logic              hit_poll;

   // 8-byte registers: byte offset bits ignored
   assign hit_poll = (paddr[CSR_ADDR_W-1:3] == ADDR_POLL_REPLY[CSR_ADDR_W-1:3]);
   assign pready   = 1'b1;

   always_comb begin
      poll_in = poll_ff;
      if (psel && penable && pwrite && pready && hit_poll) begin
         poll_in = pwdata[POLL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_ff <= POLL_RESET;
      end else begin
         poll_ff <= poll_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (hit_poll) begin
         prdata = {{(CSR_DATA_W-POLL_W){1'b0}}, poll_ff};
      end
   end

   assign poll_reply = poll_ff;

endmodule

`default_nettype wire

// ===== src/gsrs_in_stage.sv =====
`default_nettype none

module gsrs_in_stage
   import gsrs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire req_item_type in_item,
   output logic              out_valid,
   input  wire logic         out_ready,
   output req_item_type      out_item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// ===== src/gsrs_core.sv =====
`default_nettype none

module gsrs_core
   import gsrs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [POLL_W-1:0] poll_reply,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire req_item_type      in_item,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output rsp_item_type           out_item
);

   logic [3:0]   pos_ff, pos_in;
   logic [7:0]   cmd_ff, cmd_in;
   logic [7:0]   mode_ff, mode_in;
   logic [3:0]   tbl_ff, tbl_in;
   logic         tog_a_ff, tog_a_in;
   logic         tog_b_ff, tog_b_in;
   logic         done_ff, done_in;
   logic         valid_ff, valid_in;
   rsp_item_type rsp_ff, rsp_in;

   logic         step;
   logic [3:0]   pos_next;
   logic [3:0]   data_idx;
   logic [7:0]   data_byte;

   assign in_ready = !valid_ff || out_ready;
   assign step     = in_valid && in_ready;

   assign pos_next = (pos_ff < POS_MAX) ? pos_ff + 4'd1 : pos_ff;
   assign data_idx = pos_next - 4'd3;

   // table in force for this beat is the one already held: data starts at position 3
   always_comb begin
      data_byte = 8'h00;
      if (data_idx < 4'(REPLY_BYTES) && data_idx < 4'd8) begin
         if (tbl_ff == TBL_POLL) begin
            if (data_idx < 4'(POLL_BYTES)) begin
               data_byte = poll_reply[{data_idx[2:0], 3'b000} +: 8];
            end
         end else begin
            data_byte = table_byte(tbl_ff, data_idx[2:0]);
         end
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      cmd_in   = cmd_ff;
      mode_in  = mode_ff;
      tbl_in   = tbl_ff;
      tog_a_in = tog_a_ff;
      tog_b_in = tog_b_ff;
      done_in  = done_ff;
      rsp_in   = rsp_ff;
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
      if (step) begin
         if (in_item.op) begin
            pos_in  = '0;
            done_in = 1'b0;
            rsp_in.tx_byte = TX_IDLE;
         end else begin
            pos_in = pos_next;
            // command byte arrives as the second byte of the frame
            if (pos_ff == 4'd1) begin
               cmd_in = in_item.rx_byte;
               case (in_item.rx_byte)
                  CMD_41: tbl_in = TBL_41;
                  CMD_43: begin
                     if (mode_ff == MODE_DIG) begin
                        tbl_in  = TBL_43B;
                        mode_in = MODE_CONFIG;
                     end else begin
                        tbl_in  = TBL_43A;
                        mode_in = MODE_DIG;
                     end
                  end
                  CMD_44: begin
                     tbl_in  = TBL_44;
                     mode_in = MODE_ANALOG;
                  end
                  CMD_45: tbl_in = TBL_45;
                  CMD_46: begin
                     tbl_in   = tog_a_ff ? TBL_46B : TBL_46A;
                     tog_a_in = !tog_a_ff;
                  end
                  CMD_47: tbl_in = TBL_47;
                  CMD_4C: begin
                     tbl_in   = tog_b_ff ? TBL_4CB : TBL_4CA;
                     tog_b_in = !tog_b_ff;
                  end
                  CMD_4D: tbl_in = TBL_4D;
                  default: tbl_in = TBL_POLL;
               endcase
            end
            if (pos_next == 4'd1) begin
               rsp_in.tx_byte = mode_ff;
            end else if (pos_next == 4'd2) begin
               rsp_in.tx_byte = TX_ID_TAIL;
            end else begin
               rsp_in.tx_byte = data_byte;
            end
            if (in_item.select_low) begin
               done_in = 1'b1;
            end
         end
         rsp_in.frame_done     = in_item.op ? 1'b0 : (done_ff || in_item.select_low);
         rsp_in.bytes_received = pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         cmd_ff   <= '0;
         mode_ff  <= MODE_DIG;
         tbl_ff   <= TBL_POLL;
         tog_a_ff <= 1'b0;
         tog_b_ff <= 1'b0;
         done_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         cmd_ff   <= cmd_in;
         mode_ff  <= mode_in;
         tbl_ff   <= tbl_in;
         tog_a_ff <= tog_a_in;
         tog_b_ff <= tog_b_in;
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = rsp_ff;

   // command code is kept but drives no output
   logic unused_cmd;
   assign unused_cmd = ^cmd_ff;

endmodule

`default_nettype wire

// ===== src/gsrs_checker.sv =====
`default_nettype none

module gsrs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic [7:0] rsp_tx_byte,
   input wire logic       rsp_frame_done,
   input wire logic [3:0] rsp_bytes_received
);

   // nothing in flight right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // count zero only on a restart answer
   a_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bytes_received == 4'd0 |-> rsp_tx_byte == 8'hFF && !rsp_frame_done)
      else $error("restart beat malformed");

   // first byte of a frame answers the mode
   a_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bytes_received == 4'd1 |->
         rsp_tx_byte == 8'h41 || rsp_tx_byte == 8'hF3 || rsp_tx_byte == 8'h71)
      else $error("bad mode byte");

   a_id_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bytes_received == 4'd2 |-> rsp_tx_byte == 8'h5A)
      else $error("header tail not 0x5A");

endmodule

bind gamepad_spi_reply_sequencer gsrs_checker u_gsrs_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp.valid),
   .rsp_tx_byte        (rsp.tx_byte),
   .rsp_frame_done     (rsp.frame_done),
   .rsp_bytes_received (rsp.bytes_received)
);

`default_nettype wire
